// ===== design/choc_pkg.sv =====
// Shared types and constants for the choppiness index window block.
// No dependencies; used by every module in the design folder.
package choc_pkg;

  localparam int PRICE_W  = 32;
  localparam int WIN_MAX  = 64;
  localparam int PTR_W    = $clog2(WIN_MAX);
  localparam int CNT_W    = 7;
  localparam int SUM_W    = PRICE_W + PTR_W;
  localparam int POS_W    = $clog2(SUM_W);
  localparam int FRAC_W   = 16;
  localparam int LOG_W    = POS_W + FRAC_W;
  localparam int MANT_W   = 32;
  localparam int SCALE_W  = 15;
  localparam int NUM_W    = LOG_W + SCALE_W;
  localparam int QCNT_W   = $clog2(NUM_W);
  localparam int OUT_W    = 16;

  localparam logic [CNT_W-1:0]   WIN_RESET  = 7'd14;
  localparam logic [CNT_W-1:0]   WIN_LOW    = 7'd2;
  localparam logic [CNT_W-1:0]   WIN_HIGH   = 7'd64;
  localparam logic [SCALE_W-1:0] SCALE_Q88  = 15'd25600;
  localparam logic [OUT_W-1:0]   FLAT_VALUE = 16'd25600;
  localparam logic [OUT_W-1:0]   SAT_VALUE  = 16'hFFFF;

  typedef struct packed {
    logic [PRICE_W-1:0] price_high;
    logic [PRICE_W-1:0] price_low;
    logic [PRICE_W-1:0] price_close;
  } candle_t;

  typedef struct packed {
    logic [OUT_W-1:0] chop_value;
    logic             result_valid;
    logic             range_flat;
  } result_t;

  // One classified candle, handed from the front to the back.
  typedef struct packed {
    logic [PRICE_W-1:0] high;
    logic [PRICE_W-1:0] low;
    logic [PRICE_W-1:0] true_range;
    logic               live;
    logic [CNT_W-1:0]   win;
  } job_t;

endpackage

// ===== design/choc_front.sv =====
// Front end: accepts candles, computes true range and window status.
// Depends on choc_pkg.
module choc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               q_full,
  input  choc_pkg::candle_t  in_data,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_data,
  output logic               job_push,
  output choc_pkg::job_t     job_data
);

  logic [choc_pkg::CNT_W-1:0]   win_r;
  logic [choc_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [choc_pkg::PRICE_W-1:0] prev_close_r;
  logic [choc_pkg::CNT_W-1:0]   n_eff;
  logic [choc_pkg::PRICE_W-1:0] d_hl, d_hc, d_lc, tr;

  // clamp the window register
  always_comb begin
    if (win_r < choc_pkg::WIN_LOW) n_eff = choc_pkg::WIN_LOW;
    else if (win_r > choc_pkg::WIN_HIGH) n_eff = choc_pkg::WIN_HIGH;
    else n_eff = win_r;
  end

  // true range: widest of the three spans (high-low only while the candle count is zero)
  always_comb begin
    d_hl = (in_data.price_high >= in_data.price_low) ?
           in_data.price_high - in_data.price_low : in_data.price_low - in_data.price_high;
    d_hc = (in_data.price_high >= prev_close_r) ?
           in_data.price_high - prev_close_r : prev_close_r - in_data.price_high;
    d_lc = (in_data.price_low >= prev_close_r) ?
           in_data.price_low - prev_close_r : prev_close_r - in_data.price_low;
    tr = d_hl;
    if (count_r != '0) begin
      if (d_hc > tr) tr = d_hc;
      if (d_lc > tr) tr = d_lc;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (count_r < n_eff + 7'd1) count_nxt = count_r + 7'd1;
  end

  assign job_push            = in_push && !q_full;
  assign job_data.high       = in_data.price_high;
  assign job_data.low        = in_data.price_low;
  assign job_data.true_range = tr;
  assign job_data.live       = (count_nxt > n_eff);
  assign job_data.win        = n_eff;

  // advance candle count and previous close; a config write restarts warm-up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r        <= choc_pkg::WIN_RESET;
      count_r      <= '0;
      prev_close_r <= '0;
    end else if (cfg_we) begin
      win_r   <= cfg_data;
      count_r <= '0;
    end else if (job_push) begin
      count_r      <= count_nxt;
      prev_close_r <= in_data.price_close;
    end
  end

endmodule

// ===== design/choc_queue.sv =====
// Two-entry queue of classified candles between front and back.
// Depends on choc_pkg.
module choc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  choc_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output choc_pkg::job_t head
);

  choc_pkg::job_t slot_r [2];
  logic           wr_r, rd_r;
  logic [1:0]     fill_r;

  assign full  = (fill_r == 2'd2);
  assign valid = (fill_r != 2'd0);
  assign head  = slot_r[rd_r];

  // store entries
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_data;
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= 1'b0;
      rd_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop)  rd_r <= !rd_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== design/choc_back.sv =====
// Back end: window rings, scan, fixed-point logarithms, division, result register.
// Depends on choc_pkg.
module choc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  input  choc_pkg::job_t  job_head,
  output logic            job_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output choc_pkg::result_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_SCAN, S_CHECK, S_NORM, S_SQ, S_UPD, S_MULT, S_DIV, S_SAT, S_DONE
  } state_t;

  state_t state_r;

  // ring memories
  logic [choc_pkg::PRICE_W-1:0] tr_mem   [choc_pkg::WIN_MAX];
  logic [choc_pkg::PRICE_W-1:0] high_mem [choc_pkg::WIN_MAX];
  logic [choc_pkg::PRICE_W-1:0] low_mem  [choc_pkg::WIN_MAX];
  logic [choc_pkg::PRICE_W-1:0] rd_tr_r, rd_high_r, rd_low_r;

  choc_pkg::job_t               job_r;
  logic [choc_pkg::PTR_W-1:0]   ptr_r, idx_r;
  logic [choc_pkg::CNT_W-1:0]   left_r;
  logic                         rd_vld_r, first_r;
  logic [choc_pkg::SUM_W-1:0]   sum_r;
  logic [choc_pkg::PRICE_W-1:0] hi_r, lo_r;

  logic [choc_pkg::SUM_W-1:0]   x_r;
  logic [choc_pkg::POS_W-1:0]   pos_r;
  logic [choc_pkg::MANT_W-1:0]  m_r;
  logic [2*choc_pkg::MANT_W-1:0] prod_r;
  logic [choc_pkg::FRAC_W-1:0]  frac_r;
  logic [3:0]                   step_r;
  logic [1:0]                   sel_r;
  logic [choc_pkg::LOG_W-1:0]   ls_r, lr_r, ln_r;

  logic [choc_pkg::NUM_W-1:0]   num_r;
  logic [choc_pkg::LOG_W:0]     rem_r;
  logic [choc_pkg::QCNT_W-1:0]  qcnt_r;

  choc_pkg::result_t            res_r, out_r;
  logic                         out_vld_r;

  logic                         do_write, do_read, slot_free, res_load;
  logic [choc_pkg::MANT_W:0]    sq;
  logic [choc_pkg::LOG_W-1:0]   log_val;
  logic [choc_pkg::LOG_W:0]     rem_sh;
  logic [choc_pkg::LOG_W-1:0]   diff;

  assign do_write  = (state_r == S_WRITE);
  assign do_read   = (state_r == S_SCAN) && (left_r != '0);
  assign slot_free = !out_vld_r || out_pop;
  assign res_load  = (state_r == S_DONE) && slot_free;
  assign job_pop   = (state_r == S_IDLE) && job_valid;
  assign out_empty = !out_vld_r;
  assign out_data  = out_r;

  assign sq      = prod_r[2*choc_pkg::MANT_W-1:choc_pkg::MANT_W-1];
  assign log_val = {pos_r, frac_r[choc_pkg::FRAC_W-2:0], sq[choc_pkg::MANT_W]};
  assign rem_sh  = {rem_r[choc_pkg::LOG_W-1:0], num_r[choc_pkg::NUM_W-1]};
  assign diff    = ls_r - lr_r;

  // write the rings and read one entry per cycle
  always_ff @(posedge clk) begin
    if (do_write) begin
      tr_mem[ptr_r]   <= job_r.true_range;
      high_mem[ptr_r] <= job_r.high;
      low_mem[ptr_r]  <= job_r.low;
    end
    if (do_read) begin
      rd_tr_r   <= tr_mem[idx_r];
      rd_high_r <= high_mem[idx_r];
      rd_low_r  <= low_mem[idx_r];
    end
  end

  // load the result register; drop it once the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_load) begin
      out_r     <= res_r;
      out_vld_r <= 1'b1;
    end else if (out_pop) begin
      out_vld_r <= 1'b0;
    end
  end

  // sequence one candle through write, scan, logs and divide; warm-up and flat windows go straight to done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ptr_r     <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            job_r   <= job_head;
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          ptr_r   <= ptr_r + 1'b1;
          idx_r   <= ptr_r;
          left_r  <= job_r.win;
          first_r <= 1'b1;
          sum_r   <= '0;
          res_r   <= '0;
          state_r <= job_r.live ? S_SCAN : S_DONE;
        end
        S_SCAN: begin
          rd_vld_r <= do_read;
          if (do_read) begin
            idx_r  <= idx_r - 1'b1;
            left_r <= left_r - 1'b1;
          end
          if (rd_vld_r) begin
            first_r <= 1'b0;
            sum_r   <= sum_r + {{choc_pkg::PTR_W{1'b0}}, rd_tr_r};
            if (first_r || rd_high_r > hi_r) hi_r <= rd_high_r;
            if (first_r || rd_low_r < lo_r)  lo_r <= rd_low_r;
          end
          if (!do_read && !rd_vld_r) state_r <= S_CHECK;
        end
        S_CHECK: begin
          res_r.result_valid <= 1'b1;
          if (hi_r <= lo_r) begin
            res_r.chop_value <= choc_pkg::FLAT_VALUE;
            res_r.range_flat <= 1'b1;
            state_r          <= S_DONE;
          end else begin
            sel_r   <= 2'd0;
            x_r     <= sum_r;
            pos_r   <= choc_pkg::POS_W'(choc_pkg::SUM_W - 1);
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          // shift to the leading one, one bit per cycle
          if (x_r == '0) begin
            ls_r    <= '0;
            sel_r   <= 2'd1;
            x_r     <= {{choc_pkg::PTR_W{1'b0}}, hi_r - lo_r};
            pos_r   <= choc_pkg::POS_W'(choc_pkg::SUM_W - 1);
          end else if (x_r[choc_pkg::SUM_W-1]) begin
            m_r     <= x_r[choc_pkg::SUM_W-1 -: choc_pkg::MANT_W];
            frac_r  <= '0;
            step_r  <= '0;
            state_r <= S_SQ;
          end else begin
            x_r   <= x_r << 1;
            pos_r <= pos_r - 1'b1;
          end
        end
        S_SQ: begin
          prod_r  <= m_r * m_r;
          state_r <= S_UPD;
        end
        S_UPD: begin
          m_r    <= sq[choc_pkg::MANT_W] ? sq[choc_pkg::MANT_W:1] : sq[choc_pkg::MANT_W-1:0];
          frac_r <= {frac_r[choc_pkg::FRAC_W-2:0], sq[choc_pkg::MANT_W]};
          step_r <= step_r + 1'b1;
          if (step_r == 4'd15) begin
            unique case (sel_r)
              2'd0: begin
                ls_r    <= log_val;
                sel_r   <= 2'd1;
                x_r     <= {{choc_pkg::PTR_W{1'b0}}, hi_r - lo_r};
                pos_r   <= choc_pkg::POS_W'(choc_pkg::SUM_W - 1);
                state_r <= S_NORM;
              end
              2'd1: begin
                lr_r    <= log_val;
                sel_r   <= 2'd2;
                x_r     <= {{(choc_pkg::SUM_W-choc_pkg::CNT_W){1'b0}}, job_r.win};
                pos_r   <= choc_pkg::POS_W'(choc_pkg::SUM_W - 1);
                state_r <= S_NORM;
              end
              default: begin
                ln_r    <= log_val;
                state_r <= S_MULT;
              end
            endcase
          end else begin
            state_r <= S_SQ;
          end
        end
        S_MULT: begin
          if (ls_r <= lr_r) begin
            res_r.chop_value <= '0;
            state_r          <= S_DONE;
          end else begin
            num_r   <= choc_pkg::NUM_W'(diff) * choc_pkg::NUM_W'(choc_pkg::SCALE_Q88);
            rem_r   <= '0;
            qcnt_r  <= choc_pkg::QCNT_W'(choc_pkg::NUM_W - 1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (rem_sh >= {1'b0, ln_r}) begin
            rem_r <= rem_sh - {1'b0, ln_r};
            num_r <= {num_r[choc_pkg::NUM_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            num_r <= {num_r[choc_pkg::NUM_W-2:0], 1'b0};
          end
          qcnt_r <= qcnt_r - 1'b1;
          if (qcnt_r == '0) state_r <= S_SAT;
        end
        S_SAT: begin
          // clamp the quotient to the output range
          if (num_r > choc_pkg::NUM_W'(choc_pkg::SAT_VALUE))
            res_r.chop_value <= choc_pkg::SAT_VALUE;
          else
            res_r.chop_value <= num_r[choc_pkg::OUT_W-1:0];
          state_r <= S_DONE;
        end
        default: begin
          if (slot_free) state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/choppiness_index_window.sv =====
// Top level of the choppiness index window block.
// Depends on choc_pkg, choc_front, choc_queue and choc_back.
//
// Usage:
//   Input channel: drive in_data with one candle (high, low, close ticks) and
//   raise in_push; the candle transfers on a clock edge with in_push high and
//   in_full low. Result channel: while out_empty is low, out_data holds the
//   oldest result; it transfers on an edge with out_pop high.
//   Configuration: cfg_we with cfg_data writes window_length and restarts the
//   warm-up; write only while the block is idle.
// Processing:
//   A warm-up candle passes through the write and done states into the
//   result register. A full-window candle runs the ring scan over its N
//   entries, up to three logarithms on the single shared logarithm unit (a
//   normalize to the leading one, then repeated squaring), a restoring
//   divide at one quotient bit per cycle and a saturate step.
//   A two-entry queue lets two more candles transfer while one is in work.
// Reset: clears counts, ring pointer, queue and result slot; window_length returns to 14.
// Stall: a result held by the receiver stops the back end, the queue fills,
//   and in_full rises.
module choppiness_index_window (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  choc_pkg::candle_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output choc_pkg::result_t  out_data,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_data
);

  logic           q_push, q_pop, q_valid;
  choc_pkg::job_t q_in, q_head;

  choc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .q_full   (in_full),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .job_push (q_push),
    .job_data (q_in)
  );

  choc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (in_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  choc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_head  (q_head),
    .job_pop   (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // no result waits right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown after reset");

  // a flat window is always a valid result of exactly 100
  a_flat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.range_flat) |->
      (out_data.result_valid && out_data.chop_value == choc_pkg::FLAT_VALUE))
    else $error("flat result malformed");

  // a warm-up result carries zero
  a_warm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.result_valid) |->
      (out_data.chop_value == '0 && !out_data.range_flat))
    else $error("warm-up result not zero");

endmodule
